@@ hdl/lhtq_pkg.sv @@
// Shared types, constants and helper functions for the latency histogram trace queue.
package lhtq_pkg;

  // Sizing
  localparam int RING_DEPTH  = 1024;
  localparam int NUM_KINDS   = 16;
  localparam int NUM_BUCKETS = 5;
  localparam int NUM_BOUNDS  = NUM_BUCKETS - 1;
  localparam int STAT_WORDS  = 3 + NUM_BUCKETS;
  localparam int STAT_IDX_W  = $clog2(STAT_WORDS);
  localparam int STAT_W      = STAT_WORDS * 64;
  localparam int PTR_W       = $clog2(2 * RING_DEPTH);
  localparam int RING_IDX_W  = $clog2(RING_DEPTH);
  localparam int KIND_W      = $clog2(NUM_KINDS);
  localparam int BUCKET_W    = $clog2(NUM_BUCKETS);

  // Word layout of one statistics row
  localparam int W_COUNT   = 0;
  localparam int W_TOTAL   = 1;
  localparam int W_MAX     = 2;
  localparam int W_BUCKET0 = 3;

  // Histogram bucket bounds in ns, each exclusive
  localparam logic [63:0] BUCKET_BOUND [NUM_BOUNDS] = '{
    64'd500000, 64'd2000000, 64'd10000000, 64'd100000000
  };

  // Action codes
  localparam logic [1:0] ACT_OBSERVE = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // Statistic select codes
  localparam logic [3:0] SEL_BUCKET_LAST = 4'd7;
  localparam logic [3:0] SEL_DROPPED     = 4'd8;
  localparam logic [3:0] SEL_PEAK        = 4'd9;
  localparam logic [3:0] SEL_ISSUED      = 4'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [7:0]  kind;
    logic        keep;
    logic [3:0]  stat_select;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] rec_start;
    logic [63:0] rec_end;
    logic [7:0]  rec_kind;
    logic [63:0] rec_sequence;
    logic [63:0] stat_value;
  } res_t;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [7:0]  kind;
    logic [63:0] seq_num;
  } ring_record_t;

  localparam int REC_W = $bits(ring_record_t);

  typedef logic [STAT_WORDS-1:0][63:0] stat_row_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic commit;
  } ctrl_cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_FETCH,
    FSM_UPDATE
  } fsm_state_t;

  // Clamp a kind to the last statistics slot
  function automatic logic [KIND_W-1:0] kind_clamp(input logic [7:0] k);
    return (k >= 8'(NUM_KINDS - 1)) ? KIND_W'(NUM_KINDS - 1) : KIND_W'(k);
  endfunction

  // Advance a ring pointer modulo twice the depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(2 * RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Map a ring pointer onto a slot
  function automatic logic [RING_IDX_W-1:0] ring_index(input logic [PTR_W-1:0] p);
    return (p >= PTR_W'(RING_DEPTH)) ? RING_IDX_W'(p - PTR_W'(RING_DEPTH))
                                     : RING_IDX_W'(p);
  endfunction

endpackage

@@ hdl/lhtq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/lhtq_ctrl.sv @@
// Controller state machine: sequences capture, memory fetch and commit of each item.
module lhtq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output lhtq_pkg::ctrl_cmd_t ctrl_cmd
);
  import lhtq_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (start) begin
          state_next = FSM_FETCH;
        end
      end
      FSM_FETCH:  state_next = FSM_UPDATE;
      FSM_UPDATE: state_next = FSM_IDLE;
      default:    state_next = FSM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b1;
    ctrl_cmd = '0;
    case (state)
      FSM_IDLE: begin
        busy          = 1'b0;
        ctrl_cmd.load = start;
      end
      FSM_FETCH:  ctrl_cmd.fetch  = 1'b1;
      FSM_UPDATE: ctrl_cmd.commit = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

endmodule

@@ hdl/lhtq_dp.sv @@
// Datapath: statistics rows, record ring, pointers, global counters and result register.
module lhtq_dp (
  input  logic                clk,
  input  logic                rst,
  input  lhtq_pkg::cmd_t      cmd,
  input  lhtq_pkg::ctrl_cmd_t ctrl_cmd,
  output logic                done,
  output lhtq_pkg::res_t      result
);
  import lhtq_pkg::*;

  localparam logic [PTR_W:0] PTR_SPAN = (PTR_W + 1)'(2 * RING_DEPTH);

  cmd_t                 cmd_q;
  logic [KIND_W-1:0]    kind_idx;
  logic [63:0]          dur;
  logic [NUM_KINDS-1:0] row_valid;
  logic [PTR_W-1:0]     wp;
  logic [PTR_W-1:0]     rp;
  logic [63:0]          issued;
  logic [63:0]          dropped;
  logic [PTR_W-1:0]     peak;

  logic [STAT_W-1:0]    stat_rdata;
  logic [REC_W-1:0]     ring_rdata;
  stat_row_t            row_old;
  stat_row_t            row_new;
  ring_record_t         rec_rd;
  ring_record_t         rec_wr;
  logic [PTR_W-1:0]     fill;
  logic                 full;
  logic                 empty;
  logic [BUCKET_W-1:0]  bucket_idx;
  logic [63:0]          seq;
  logic                 is_observe;
  logic                 is_pop;
  logic                 stat_wr;
  logic                 ring_wr;
  logic [63:0]          stat_value;
  res_t                 result_next;

  // Capture the item and its clamped kind
  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      cmd_q    <= cmd;
      kind_idx <= kind_clamp(cmd.kind);
    end
  end

  // Register the duration, zero when end precedes start
  always_ff @(posedge clk) begin
    if (ctrl_cmd.fetch) begin
      dur <= (cmd_q.end_ns >= cmd_q.start_ns) ? cmd_q.end_ns - cmd_q.start_ns : '0;
    end
  end

  // Ring occupancy from the pointers
  always_comb begin
    if (wp >= rp) begin
      fill = wp - rp;
    end else begin
      fill = PTR_W'({1'b0, wp} + PTR_SPAN - {1'b0, rp});
    end
    full  = (fill >= PTR_W'(RING_DEPTH));
    empty = (fill == '0);
  end

  assign is_observe = (cmd_q.action == ACT_OBSERVE);
  assign is_pop     = (cmd_q.action == ACT_POP);
  assign seq        = issued + 64'd1;
  assign stat_wr    = ctrl_cmd.commit && is_observe;
  assign ring_wr    = stat_wr && cmd_q.keep && !full;

  // Pick the histogram bucket
  always_comb begin
    bucket_idx = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      bucket_idx = bucket_idx + BUCKET_W'(dur >= BUCKET_BOUND[i]);
    end
  end

  // Update the statistics row; a row never written reads as zero
  always_comb begin
    row_old = row_valid[kind_idx] ? stat_row_t'(stat_rdata) : '0;
    row_new = row_old;
    row_new[W_COUNT] = row_old[W_COUNT] + 64'd1;
    row_new[W_TOTAL] = row_old[W_TOTAL] + dur;
    row_new[W_MAX]   = (dur > row_old[W_MAX]) ? dur : row_old[W_MAX];
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      row_new[W_BUCKET0 + b] = row_old[W_BUCKET0 + b] + 64'(bucket_idx == BUCKET_W'(b));
    end
  end

  // Build the record to push
  always_comb begin
    rec_wr.start_ns = cmd_q.start_ns;
    rec_wr.end_ns   = cmd_q.end_ns;
    rec_wr.kind     = cmd_q.kind;
    rec_wr.seq_num  = seq;
  end

  assign rec_rd = ring_record_t'(ring_rdata);

  // Select the statistic to read
  always_comb begin
    stat_value = '0;
    if (cmd_q.stat_select <= SEL_BUCKET_LAST) begin
      stat_value = row_old[cmd_q.stat_select[STAT_IDX_W-1:0]];
    end else begin
      case (cmd_q.stat_select)
        SEL_DROPPED: stat_value = dropped;
        SEL_PEAK:    stat_value = 64'(peak);
        SEL_ISSUED:  stat_value = issued;
        default:     stat_value = '0;
      endcase
    end
  end

  // Form the result
  always_comb begin
    result_next = '0;
    case (cmd_q.action)
      ACT_OBSERVE: begin
        if (cmd_q.keep && full) begin
          result_next.status = ST_DROPPED;
        end
      end
      ACT_POP: begin
        if (empty) begin
          result_next.status = ST_EMPTY;
        end else begin
          result_next.rec_start    = rec_rd.start_ns;
          result_next.rec_end      = rec_rd.end_ns;
          result_next.rec_kind     = rec_rd.kind;
          result_next.rec_sequence = rec_rd.seq_num;
        end
      end
      ACT_READ: result_next.stat_value = stat_value;
      default:  result_next = '0;
    endcase
  end

  // Advance pointers and global counters on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      wp        <= '0;
      rp        <= '0;
      issued    <= '0;
      dropped   <= '0;
      peak      <= '0;
    end else if (ctrl_cmd.commit) begin
      if (is_observe) begin
        row_valid[kind_idx] <= 1'b1;
        if (cmd_q.keep) begin
          issued <= seq;
          if (full) begin
            dropped <= dropped + 64'd1;
          end else begin
            wp <= ptr_next(wp);
            if (fill + 1'b1 > peak) begin
              peak <= fill + 1'b1;
            end
          end
        end
      end else if (is_pop && !empty) begin
        rp <= ptr_next(rp);
      end
    end
  end

  // Flag the result with done, registered from commit
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.commit) begin
      result <= result_next;
    end
  end

  // Per-kind statistics rows
  lhtq_ram #(
    .WIDTH (STAT_W),
    .DEPTH (NUM_KINDS)
  ) u_stat_ram (
    .clk     (clk),
    .wr_en   (stat_wr),
    .wr_addr (kind_idx),
    .wr_data (STAT_W'(row_new)),
    .rd_en   (ctrl_cmd.fetch),
    .rd_addr (kind_idx),
    .rd_data (stat_rdata)
  );

  // Record ring storage
  lhtq_ram #(
    .WIDTH (REC_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (ring_index(wp)),
    .wr_data (REC_W'(rec_wr)),
    .rd_en   (ctrl_cmd.fetch),
    .rd_addr (ring_index(rp)),
    .rd_data (ring_rdata)
  );

endmodule

@@ hdl/latency_histogram_trace_queue.sv @@
// Top level of the latency histogram trace queue: controller, datapath and checks.
//
// Usage:
//   Drive an item on cmd and raise start; it is taken at a rising edge where
//   start is high and busy is low. Actions: observe (update per-kind count,
//   total, maximum and histogram, optionally push the record into the ring),
//   pop (remove the oldest record) and read (return one statistic).
//   Each item gives exactly one result on result, marked by done for a
//   single cycle; the receiver cannot stall, so it must take it then.
// Timing:
//   An item passes through accept, memory fetch (statistics row and ring
//   slot are read from registered-read RAMs), then update and commit. done
//   rises at the edge that ends the commit cycle, and the result is taken
//   at the edge that ends the cycle in which done is high. busy is high
//   during fetch and commit, so a new item is taken only after the previous
//   one has committed, at best while the previous result is still shown.
// Reset:
//   rst clears statistics (through per-kind row valid bits), pointers and
//   counters at once; no clearing pass is needed. Ring contents are not
//   cleared, and a pop reads only slots that were pushed.
module latency_histogram_trace_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lhtq_pkg::cmd_t   cmd,
  output logic             done,
  output lhtq_pkg::res_t   result
);
  import lhtq_pkg::*;

  ctrl_cmd_t ctrl_cmd;

  lhtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .ctrl_cmd (ctrl_cmd)
  );

  lhtq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ctrl_cmd (ctrl_cmd),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTHESIS
  // Each commit delivers its result on the next cycle
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.commit |=> done)
    else $error("commit did not produce a result");

  // Controller issues at most one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl_cmd.load, ctrl_cmd.fetch, ctrl_cmd.commit}))
    else $error("overlapping controller commands");

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accept");

  // A pop on an empty ring returns no record
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (result.rec_sequence == '0))
    else $error("empty pop returned a record");
`endif

endmodule
